>>> hw/rtl/nrpr_pkg.sv
`default_nettype none

package nrpr_pkg;

	// Configuration register map, as word indexes.
	localparam int unsigned REG_ROW_WIDTH = 0;
	localparam int unsigned APB_ADDR_W    = 3;
	localparam int unsigned APB_DATA_W    = 32;

	// Row width after reset, in pixels.
	localparam logic [7:0] ROW_WIDTH_RESET = 8'd128;

	// A zero row width counts as 256 pixels, which is 128 bytes per row.
	localparam logic [7:0] ZERO_WIDTH_LAST = 8'd127;

	// Keeps the high pixel of a byte and pads the low one.
	localparam logic [7:0] NIB_HI_MASK = 8'hf0;

	// One display byte with its row marker.
	typedef struct packed {
		logic [7:0] data;
		logic       row_end;
	} nrpr_result_t;

	// All results that one input byte causes: one or two.
	typedef struct packed {
		nrpr_result_t first;
		nrpr_result_t second;
		logic         two;
	} nrpr_pair_t;

endpackage

`default_nettype wire

>>> hw/rtl/nibble_row_pad_repacker_core.sv
// Row realigning repacker for streams of 4-bit gray pixels.
//
// Input channel (in_valid / in_stall): one byte of two pixels per
// transaction, high nibble first, rows packed with no gap. end_of_image
// marks the last byte of a picture and returns the block to an aligned row.
// Output channel (out_valid / out_stall): display bytes with every row
// starting on a byte boundary; row_end marks the last byte of a row and
// last_of_run the final result of one input byte.
// The user writes row_width over the APB port at byte address 0 only
// while idle; the block itself does not enforce it.
// A byte goes through the input register and the result register to its
// first result. One input byte is taken per cycle while the result
// register is free; a byte that gives two results (the end of a shifted
// row with an odd width, or a byte at width one not ending the image)
// holds the result register until both are taken. When the receiver
// stalls, the result register holds its transaction and the input
// register still takes one more byte before in_stall rises. Reset clears
// the row state, empties both registers and sets row_width to 128 pixels.

`default_nettype none

module nibble_row_pad_repacker_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [nrpr_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [nrpr_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [nrpr_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [7:0]                      pixel_pair,
	input  wire logic                            end_of_image,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [7:0]                      out_byte,
	output logic                                 row_end,
	output logic                                 last_of_run
);

	logic                 valid_s1;
	logic [7:0]           pixel_s1;
	logic                 eoi_s1;
	logic [7:0]           row_width;
	logic                 can_load;
	logic                 advance;
	logic                 accept;
	nrpr_pkg::nrpr_pair_t pair;

	nrpr_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.row_width (row_width)
	);

	// Input register handshake.
	assign advance  = valid_s1 & can_load;
	assign in_stall = valid_s1 & ~can_load;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel_pair;
			eoi_s1   <= end_of_image;
		end
	end

	nrpr_realign u_realign (
		.clk          (clk),
		.arst_n       (arst_n),
		.row_width    (row_width),
		.advance      (advance),
		.pixel_pair   (pixel_s1),
		.end_of_image (eoi_s1),
		.pair         (pair)
	);

	nrpr_result_buf u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.pair        (pair),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.row_end     (row_end),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

>>> hw/rtl/nrpr_apb_regs.sv
`default_nettype none

module nrpr_apb_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [nrpr_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [nrpr_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [nrpr_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	output logic      [7:0]                      row_width
);

	logic [7:0] row_width_q;
	logic       sel_row_width;
	logic       wr_en;

	// The register index is the word address; the byte offset is ignored.
	assign sel_row_width = (paddr[nrpr_pkg::APB_ADDR_W-1:2] ==
		nrpr_pkg::REG_ROW_WIDTH[nrpr_pkg::APB_ADDR_W-3:0]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Row width register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= nrpr_pkg::ROW_WIDTH_RESET;
		end else if (wr_en && sel_row_width) begin
			row_width_q <= pwdata[7:0];
		end
	end

	// Read data mux.
	always_comb begin
		prdata = '0;
		if (sel_row_width) begin
			prdata = {{(nrpr_pkg::APB_DATA_W-8){1'b0}}, row_width_q};
		end
	end

	assign row_width = row_width_q;

endmodule

`default_nettype wire

>>> hw/rtl/nrpr_realign.sv
`default_nettype none

module nrpr_realign (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [7:0]           row_width,
	input  wire logic                 advance,
	input  wire logic [7:0]           pixel_pair,
	input  wire logic                 end_of_image,
	output nrpr_pkg::nrpr_pair_t      pair
);

	logic [3:0] carry_nibble_q;
	logic [7:0] byte_in_row_q;
	logic       shifted_row_q;
	logic [3:0] carry_nibble_d;
	logic [7:0] byte_in_row_d;
	logic       shifted_row_d;
	logic [6:0] half;
	logic [7:0] last_idx;
	logic       rend;

	assign half = row_width[7:1];

	// Results and next row state for the byte in the input register.
	always_comb begin
		pair           = '0;
		carry_nibble_d = carry_nibble_q;
		byte_in_row_d  = byte_in_row_q;
		shifted_row_d  = shifted_row_q;
		last_idx       = '0;
		rend           = 1'b0;

		if (!row_width[0]) begin
			// Even width: bytes pass through, only the count matters.
			last_idx = (row_width == 8'd0) ? nrpr_pkg::ZERO_WIDTH_LAST :
				({1'b0, half} - 8'd1);
			rend = end_of_image | (byte_in_row_q >= last_idx);
			pair.first.data    = pixel_pair;
			pair.first.row_end = rend;
			byte_in_row_d = rend ? 8'd0 : (byte_in_row_q + 8'd1);
		end else if (half == 7'd0) begin
			// Width one: every byte splits into two single-pixel rows.
			pair.first.data     = pixel_pair & nrpr_pkg::NIB_HI_MASK;
			pair.first.row_end  = 1'b1;
			pair.second.data    = {pixel_pair[3:0], 4'b0000};
			pair.second.row_end = 1'b1;
			pair.two            = ~end_of_image;
			carry_nibble_d = 4'd0;
			byte_in_row_d  = 8'd0;
			shifted_row_d  = 1'b0;
		end else if (!shifted_row_q) begin
			// Aligned row: the last byte leaves its low pixel as carry.
			last_idx = {1'b0, half};
			rend = end_of_image | (byte_in_row_q >= last_idx);
			if (rend) begin
				pair.first.data    = pixel_pair & nrpr_pkg::NIB_HI_MASK;
				pair.first.row_end = 1'b1;
				carry_nibble_d = pixel_pair[3:0];
				byte_in_row_d  = 8'd0;
				shifted_row_d  = 1'b1;
			end else begin
				pair.first.data    = pixel_pair;
				pair.first.row_end = 1'b0;
				byte_in_row_d = byte_in_row_q + 8'd1;
			end
		end else begin
			// Shifted row: carry and pixels move up one nibble.
			last_idx = {1'b0, half} - 8'd1;
			rend = end_of_image | (byte_in_row_q >= last_idx);
			pair.first.data    = {carry_nibble_q, pixel_pair[7:4]};
			pair.first.row_end = 1'b0;
			carry_nibble_d = pixel_pair[3:0];
			if (rend) begin
				pair.second.data    = {pixel_pair[3:0], 4'b0000};
				pair.second.row_end = 1'b1;
				pair.two            = 1'b1;
				carry_nibble_d = 4'd0;
				byte_in_row_d  = 8'd0;
				shifted_row_d  = 1'b0;
			end else begin
				byte_in_row_d = byte_in_row_q + 8'd1;
			end
		end

		// The end of an image returns to an aligned first row.
		if (end_of_image) begin
			carry_nibble_d = 4'd0;
			byte_in_row_d  = 8'd0;
			shifted_row_d  = 1'b0;
		end
	end

	// Row state moves on when the results enter the result buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_nibble_q <= 4'd0;
			byte_in_row_q  <= 8'd0;
			shifted_row_q  <= 1'b0;
		end else if (advance) begin
			carry_nibble_q <= carry_nibble_d;
			byte_in_row_q  <= byte_in_row_d;
			shifted_row_q  <= shifted_row_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/nrpr_result_buf.sv
`default_nettype none

module nrpr_result_buf (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire nrpr_pkg::nrpr_pair_t pair,
	output logic                      can_load,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [7:0]           out_byte,
	output logic                      row_end,
	output logic                      last_of_run
);

	nrpr_pkg::nrpr_pair_t pair_s2;
	logic                 valid_s2;
	logic                 second_q;
	logic                 taken;
	logic                 drained;

	assign out_valid   = valid_s2;
	assign out_byte    = second_q ? pair_s2.second.data : pair_s2.first.data;
	assign row_end     = second_q ? pair_s2.second.row_end : pair_s2.first.row_end;
	assign last_of_run = second_q | ~pair_s2.two;

	assign taken    = valid_s2 & ~out_stall;
	assign drained  = taken & last_of_run;
	assign can_load = ~valid_s2 | drained;

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			pair_s2 <= pair;
		end
	end

	// Valid flag and the pointer to the second result of a pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			second_q <= 1'b0;
		end else if (drained) begin
			valid_s2 <= 1'b0;
			second_q <= 1'b0;
		end else if (taken) begin
			second_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/nrpr_checker.sv
`default_nettype none

module nrpr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       row_end,
	input wire logic       last_of_run
);

	// A stalled result transaction holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) &&
			$stable(row_end) && $stable(last_of_run))
		else $error("stalled result changed");

	// The second result of a pair follows right away and closes a row.
	a_pair_second: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=>
			out_valid && row_end && last_of_run)
		else $error("second result of a pair missing or malformed");

	// With the result register empty the input never stalls.
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while result register empty");

	// An input stall with a free output means a pair is still draining.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |-> out_valid && !last_of_run)
		else $error("input stalled without cause");

endmodule

bind nibble_row_pad_repacker_core nrpr_checker u_nrpr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_byte    (out_byte),
	.row_end     (row_end),
	.last_of_run (last_of_run)
);

`default_nettype wire

>>> dv/nrpr_repack_checker.sv
// Watches both channels and the register port of the repacker, predicts the
// display bytes of every accepted pixel pair and compares them in order.
module nrpr_repack_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [nrpr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [nrpr_pkg::APB_DATA_W-1:0] pwdata,
	input  logic                            pready,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [7:0]                      pixel_pair,
	input  logic                            end_of_image,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [7:0]                      out_byte,
	input  logic                            row_end,
	input  logic                            last_of_run,
	output int                              failures,
	output int                              bytes_owed
);

	// One predicted display byte with its markers.
	typedef struct packed {
		logic [7:0] data;
		logic       row_end;
		logic       last;
	} disp_byte_t;

	disp_byte_t  owed_bytes[$];

	// Own copy of the register and of the row state.
	logic [7:0]  width_px;
	logic [3:0]  carry_nib;
	logic [7:0]  col_byte;
	logic        in_shifted_row;

	// Works out the display bytes of one pixel pair and queues them.
	task automatic repack_pixel_pair(input logic [7:0] px, input logic eoi);
		disp_byte_t run[2];
		int         n;
		int         w;
		int         bpr;
		logic       rend;
		n = 0;
		w = (width_px == 8'd0) ? 256 : int'(width_px);
		if (w % 2 == 0) begin
			// Even width: the byte passes through.
			rend = eoi || (int'(col_byte) >= w / 2 - 1);
			run[n] = {px, rend, 1'b0};
			n++;
			col_byte = rend ? 8'd0 : col_byte + 8'd1;
		end else if (w == 1) begin
			// Width one: high pixel padded, then low pixel moved up.
			run[n] = {px & nrpr_pkg::NIB_HI_MASK, 1'b1, 1'b0};
			n++;
			if (!eoi) begin
				run[n] = {px[3:0], 4'h0, 1'b1, 1'b0};
				n++;
			end
			col_byte = 8'd0;
			in_shifted_row = 1'b0;
			carry_nib = 4'h0;
		end else begin
			bpr = w / 2 + 1;
			if (!in_shifted_row) begin
				// Aligned row: the last byte keeps its low pixel as the carry.
				if (int'(col_byte) >= bpr - 1 || eoi) begin
					run[n] = {px & nrpr_pkg::NIB_HI_MASK, 1'b1, 1'b0};
					n++;
					carry_nib = px[3:0];
					col_byte = 8'd0;
					in_shifted_row = 1'b1;
				end else begin
					run[n] = {px, 1'b0, 1'b0};
					n++;
					col_byte = col_byte + 8'd1;
				end
			end else begin
				// Shifted row: every pixel moves up by one nibble.
				rend = int'(col_byte) >= bpr - 2;
				run[n] = {carry_nib, px[7:4], 1'b0, 1'b0};
				n++;
				carry_nib = px[3:0];
				if (rend || eoi) begin
					run[n] = {carry_nib, 4'h0, 1'b1, 1'b0};
					n++;
					carry_nib = 4'h0;
					col_byte = 8'd0;
					in_shifted_row = 1'b0;
				end else begin
					col_byte = col_byte + 8'd1;
				end
			end
		end
		if (eoi) begin
			carry_nib = 4'h0;
			col_byte = 8'd0;
			in_shifted_row = 1'b0;
		end
		run[n - 1].last = 1'b1;
		for (int k = 0; k < n; k++)
			owed_bytes.push_back(run[k]);
	endtask

	// Follow register writes, predict on input transactions and check output
	// transactions against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		disp_byte_t want;
		if (!arst_n) begin
			width_px = nrpr_pkg::ROW_WIDTH_RESET;
			carry_nib = 4'h0;
			col_byte = 8'd0;
			in_shifted_row = 1'b0;
			owed_bytes.delete();
			failures = 0;
		end else begin
			if (psel && penable && pwrite && pready
					&& paddr == 3'(nrpr_pkg::REG_ROW_WIDTH * 4))
				width_px = pwdata[7:0];
			if (in_valid && !in_stall)
				repack_pixel_pair(pixel_pair, end_of_image);
			if (out_valid && !out_stall) begin
				if (owed_bytes.size() == 0) begin
					$error("unexpected transaction: out_byte %h row_end %b last_of_run %b",
						out_byte, row_end, last_of_run);
					failures++;
				end else begin
					want = owed_bytes.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %h, actual %h", want.data, out_byte);
						failures++;
					end
					if (row_end !== want.row_end) begin
						$error("row_end: expected %b, actual %b", want.row_end, row_end);
						failures++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %b, actual %b", want.last, last_of_run);
						failures++;
					end
				end
			end
		end
		bytes_owed = owed_bytes.size();
	end

endmodule

>>> dv/tb_nibble_row_pad_repacker_core.sv
// Stimulus and verdict for the nibble row repacker.
module tb_nibble_row_pad_repacker_core;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [nrpr_pkg::APB_ADDR_W-1:0] paddr;
	logic [nrpr_pkg::APB_DATA_W-1:0] pwdata;
	logic [nrpr_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;
	logic                            in_valid;
	logic                            in_stall;
	logic [7:0]                      pixel_pair;
	logic                            end_of_image;
	logic                            out_valid;
	logic                            out_stall;
	logic [7:0]                      out_byte;
	logic                            row_end;
	logic                            last_of_run;
	int                              failures;
	int                              bytes_owed;

	// Set per phase: no idle cycles on either side.
	bit                              calm;
	// Asks the receiver for one long hold-off.
	bit                              choke_req;

	nibble_row_pad_repacker_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_pair   (pixel_pair),
		.end_of_image (end_of_image),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.row_end      (row_end),
		.last_of_run  (last_of_run)
	);

	nrpr_repack_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_pair   (pixel_pair),
		.end_of_image (end_of_image),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.row_end      (row_end),
		.last_of_run  (last_of_run),
		.failures     (failures),
		.bytes_owed   (bytes_owed)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run.
	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

	// Idle length: mostly none, often short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Receiver: random stalls, and one long hold-off on request.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (choke_req) begin
				out_stall <= 1'b1;
				repeat (80) @(negedge clk);
				choke_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				n = idle_len();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Offers one pixel pair after a random gap; returns at the falling edge
	// after the transaction, with valid still high.
	task automatic offer(input logic [7:0] px, input logic eoi);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		pixel_pair   <= px;
		end_of_image <= eoi;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stops offering and waits until every predicted byte has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (bytes_owed != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_width(input logic [7:0] w);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(nrpr_pkg::REG_ROW_WIDTH * 4);
		pwdata  <= {24'h0, w};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		logic [7:0] w;
		int         n_items;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		pixel_pair   = 8'h00;
		end_of_image = 1'b0;
		calm         = 1'b0;
		choke_req    = 1'b0;
		arst_n       = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Width after reset, with an end of image inside the row.
		offer(8'h00, 1'b0);
		offer(8'hff, 1'b0);
		offer(8'h5a, 1'b1);
		drain();

		// Width three: aligned rows of two bytes, shifted rows of one byte
		// giving two, end of image in an aligned row and in a shifted row.
		write_width(8'd3);
		offer(8'hff, 1'b0);
		offer(8'h00, 1'b0);
		offer(8'ha5, 1'b0);
		offer(8'h12, 1'b0);
		offer(8'h34, 1'b0);
		offer(8'h56, 1'b0);
		offer(8'h78, 1'b1);
		offer(8'h9c, 1'b0);
		offer(8'hde, 1'b0);
		offer(8'hf1, 1'b1);
		offer(8'h0f, 1'b0);
		drain();

		// Width one: two results per byte, one at the end of the image.
		write_width(8'd1);
		offer(8'h81, 1'b0);
		offer(8'h7e, 1'b0);
		offer(8'hc3, 1'b1);
		offer(8'h00, 1'b0);
		drain();

		// Even width of three bytes, end of image mid row.
		write_width(8'd6);
		offer(8'h11, 1'b0);
		offer(8'h22, 1'b1);
		offer(8'h33, 1'b0);
		offer(8'h44, 1'b0);
		offer(8'h55, 1'b0);
		drain();

		// Random phases; a phase may stop mid row so the next width takes
		// over a row in progress.
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: w = 8'd255;
				1: w = 8'd0;
				2: w = 8'd1;
				3: w = 8'd254;
				default: begin
					w = 8'($urandom_range(1, 15));
					if ($urandom_range(0, 3) != 0)
						w[0] = 1'b1;
				end
			endcase
			n_items = (ph < 2) ? 135 : 30;
			write_width(w);
			calm = ($urandom_range(0, 3) == 0);
			if (ph == 4) begin
				calm = 1'b1;
				choke_req = 1'b1;
			end
			for (int i = 0; i < n_items; i++)
				offer(8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
			calm = 1'b0;
			drain();
		end

		repeat (10) @(negedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
